// ===== rtl/nak_retransmit_window_sender_assert.svh =====
// ----------------------------------------------------------------------------
// NAK retransmit sender assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef NAK_RETRANSMIT_WINDOW_SENDER_ASSERT_SVH
`define NAK_RETRANSMIT_WINDOW_SENDER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define NRWS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define NRWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/nrws_pkg.sv =====
// ----------------------------------------------------------------------------
// nrws_pkg
// Types, codes and constants shared by the NAK retransmit sender modules.
// ----------------------------------------------------------------------------
package nrws_pkg;

    // Field and register widths
    localparam int SEQ_W      = 32;
    localparam int WC_W       = 4;
    localparam int WSIZE_W    = 4;
    localparam int LIMIT_W    = 16;
    localparam int REG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Defaults and reset values
    localparam int                 MAX_WINDOW_DEF  = 8;
    localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST = 4'd5;
    localparam logic [LIMIT_W-1:0] SEQ_LIMIT_RST   = 16'd50;
    localparam logic [SEQ_W-1:0]   NEXT_SEQ_RST    = 32'd1;
    localparam logic [WC_W-1:0]    WC_MAX          = 4'hF;

    // Input function codes
    localparam logic FUNC_REPLY = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_SEQ_LIMIT   = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FL_START,
        ST_RS_ADDR,
        ST_RS_EMIT,
        ST_BURST,
        ST_FL_END,
        ST_SR_ADDR,
        ST_SR_CMP,
        ST_COMMIT
    } state_t;

    // Shared unit operations
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_EQ,
        ALU_LT
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [SEQ_W-1:0] a;
        logic [SEQ_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic             flag;
        logic [SEQ_W-1:0] sum;
    } alu_res_t;

    // One transmitted packet
    typedef struct packed {
        logic [SEQ_W-1:0] packet_value;
        logic             is_resend;
        logic             last;
    } pkt_t;

endpackage

// ===== rtl/nrws_alu.sv =====
// ----------------------------------------------------------------------------
// nrws_alu
// Shared 32-bit adder and comparator used by the sequencer for sequence
// increments, duplicate search and the burst limit check.
// ----------------------------------------------------------------------------
module nrws_alu
    import nrws_pkg::*;
(
    input  alu_req_t req,
    output alu_res_t res
);

    // Add always, pick the compare by opcode
    always_comb
    begin
        res.sum = req.a + req.b;
        unique case (req.op)
            ALU_EQ:  res.flag = (req.a == req.b);
            ALU_LT:  res.flag = (req.a < req.b);
            ALU_ADD: res.flag = 1'b0;
            default: res.flag = 1'b0;
        endcase
    end

endmodule

// ===== rtl/nrws_list.sv =====
// ----------------------------------------------------------------------------
// nrws_list
// Resend list storage: one write port and one registered read port.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module nrws_list
    import nrws_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [SEQ_W-1:0] wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [SEQ_W-1:0] rd_data
);

    logic [SEQ_W-1:0] mem [MAX_WINDOW];
    logic [SEQ_W-1:0] rd_data_reg;

    // Write on request, read every cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/nrws_seq.sv =====
// ----------------------------------------------------------------------------
// nrws_seq
// Sequencer: duplicate search and insert for replies, and the flush walk
// that sends the resend list followed by a fresh burst.
// ----------------------------------------------------------------------------
`include "nak_retransmit_window_sender_assert.svh"

module nrws_seq
    import nrws_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               func,
    input  logic [SEQ_W-1:0]   reply_value,
    output logic               in_stall,
    input  logic [WSIZE_W-1:0] window_size,
    input  logic [LIMIT_W-1:0] seq_limit,
    output logic               emit_valid,
    input  logic               emit_ready,
    output pkt_t               emit,
    output alu_req_t           alu_req,
    input  alu_res_t           alu_res,
    output logic               wr_en,
    output logic [IDX_W-1:0]   wr_addr,
    output logic [SEQ_W-1:0]   wr_data,
    output logic [IDX_W-1:0]   rd_addr,
    input  logic [SEQ_W-1:0]   rd_data
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] rc_reg, rc_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [WC_W-1:0]  wc_reg, wc_next;
    logic [WC_W-1:0]  burst_reg, burst_next;
    logic [SEQ_W-1:0] next_seq_reg, next_seq_next;
    logic [SEQ_W-1:0] reply_reg, reply_next;
    logic             pend_reg, pend_next;
    logic             found_reg, found_next;
    logic             burst_en_reg, burst_en_next;
    logic [WC_W-1:0]  eff_win;
    logic             emit_fire;
    logic             rs_done;
    logic             burst_done;
    logic             full_window;

    // Clamp the window size to 1..MAX_WINDOW
    always_comb
    begin
        if (window_size == '0)
        begin
            eff_win = WC_W'(1);
        end
        else if (int'(window_size) > MAX_WINDOW)
        begin
            eff_win = WC_W'(MAX_WINDOW);
        end
        else
        begin
            eff_win = window_size;
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign emit_valid  = (state_reg == ST_RS_EMIT) || (state_reg == ST_BURST);
    assign emit_fire   = emit_valid && emit_ready;
    assign rs_done     = ((idx_reg + CNT_W'(1)) == rc_reg);
    assign burst_done  = ((burst_reg + WC_W'(1)) == eff_win);
    assign full_window = (wc_reg >= eff_win);
    assign rd_addr     = idx_reg[IDX_W-1:0];
    assign wr_addr     = rc_reg[IDX_W-1:0];
    assign wr_data     = reply_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == FUNC_FLUSH || full_window)
                    begin
                        state_next = ST_FL_START;
                    end
                    else if (reply_value != '0 && rc_reg != '0)
                    begin
                        state_next = ST_SR_ADDR;
                    end
                    else
                    begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_FL_START:
            begin
                if (rc_reg != '0)
                begin
                    state_next = ST_RS_ADDR;
                end
                else if (alu_res.flag)
                begin
                    state_next = ST_BURST;
                end
                else
                begin
                    state_next = ST_FL_END;
                end
            end
            ST_RS_ADDR:
            begin
                state_next = ST_RS_EMIT;
            end
            ST_RS_EMIT:
            begin
                if (emit_ready)
                begin
                    if (!rs_done)
                    begin
                        state_next = ST_RS_ADDR;
                    end
                    else if (burst_en_reg)
                    begin
                        state_next = ST_BURST;
                    end
                    else
                    begin
                        state_next = ST_FL_END;
                    end
                end
            end
            ST_BURST:
            begin
                if (emit_ready && burst_done)
                begin
                    state_next = ST_FL_END;
                end
            end
            ST_FL_END:
            begin
                state_next = pend_reg ? ST_COMMIT : ST_IDLE;
            end
            ST_SR_ADDR:
            begin
                state_next = ST_SR_CMP;
            end
            ST_SR_CMP:
            begin
                if (alu_res.flag || rs_done)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    state_next = ST_SR_ADDR;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath updates, shared unit requests and emitted packet
    always_comb
    begin
        rc_next       = rc_reg;
        idx_next      = idx_reg;
        wc_next       = wc_reg;
        burst_next    = burst_reg;
        next_seq_next = next_seq_reg;
        reply_next    = reply_reg;
        pend_next     = pend_reg;
        found_next    = found_reg;
        burst_en_next = burst_en_reg;
        wr_en         = 1'b0;
        alu_req       = '{op: ALU_ADD, a: next_seq_reg, b: SEQ_W'(1)};
        emit          = '{packet_value: next_seq_reg, is_resend: 1'b0, last: burst_done};
        unique case (state_reg)
            ST_IDLE:
            begin
                // Capture the item and remember whether a reply waits on a flush
                if (in_valid)
                begin
                    reply_next = reply_value;
                    found_next = 1'b0;
                    idx_next   = '0;
                    pend_next  = (func != FUNC_FLUSH);
                end
            end
            ST_FL_START:
            begin
                // Decide on the burst once, before anything is sent
                alu_req       = '{op: ALU_LT, a: next_seq_reg, b: SEQ_W'(seq_limit)};
                burst_en_next = alu_res.flag;
                idx_next      = '0;
                burst_next    = '0;
            end
            ST_RS_EMIT:
            begin
                emit = '{packet_value: rd_data, is_resend: 1'b1,
                         last: rs_done && !burst_en_reg};
                if (emit_fire)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_BURST:
            begin
                // Advance the sequence through the shared adder
                if (emit_fire)
                begin
                    next_seq_next = alu_res.sum;
                    burst_next    = burst_reg + WC_W'(1);
                end
            end
            ST_FL_END:
            begin
                rc_next = '0;
                wc_next = '0;
            end
            ST_SR_CMP:
            begin
                alu_req    = '{op: ALU_EQ, a: rd_data, b: reply_reg};
                found_next = alu_res.flag;
                idx_next   = idx_reg + CNT_W'(1);
            end
            ST_COMMIT:
            begin
                // Append a new, nonzero NAK if there is room, then count the reply
                if (reply_reg != '0 && !found_reg && rc_reg < CNT_W'(MAX_WINDOW))
                begin
                    wr_en   = 1'b1;
                    rc_next = rc_reg + CNT_W'(1);
                end
                if (wc_reg != WC_MAX)
                begin
                    wc_next = wc_reg + WC_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rc_reg       <= '0;
            idx_reg      <= '0;
            wc_reg       <= '0;
            burst_reg    <= '0;
            next_seq_reg <= NEXT_SEQ_RST;
            pend_reg     <= 1'b0;
            found_reg    <= 1'b0;
            burst_en_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rc_reg       <= rc_next;
            idx_reg      <= idx_next;
            wc_reg       <= wc_next;
            burst_reg    <= burst_next;
            next_seq_reg <= next_seq_next;
            pend_reg     <= pend_next;
            found_reg    <= found_next;
            burst_en_reg <= burst_en_next;
        end
    end

    // Held reply value
    always_ff @(posedge clk)
    begin
        reply_reg <= reply_next;
    end

    // Checks
    `NRWS_ASSERT_SAME(a_rc_bound, clk, rst_n, 1'b1, int'(rc_reg) <= MAX_WINDOW, "resend count over capacity")
    `NRWS_ASSERT_NEXT(a_last_ends_flush, clk, rst_n, emit_fire && emit.last, state_reg == ST_FL_END, "last packet did not end the flush")
    `NRWS_ASSERT_NEXT(a_flush_clears, clk, rst_n, state_reg == ST_FL_END, rc_reg == '0 && wc_reg == '0, "flush left counts set")
    `NRWS_ASSERT_NEXT(a_burst_step, clk, rst_n, emit_fire && !emit.is_resend, next_seq_reg == $past(next_seq_reg) + SEQ_W'(1), "burst packet did not advance sequence")

endmodule

// ===== rtl/nak_retransmit_window_sender.sv =====
// Reply item: a nonzero reply is searched entry by entry (list read is registered), then committed.
// Flush item: setup, then address and emit states per resend, then the burst, then a clear;
//   a first resend goes through ST_RS_ADDR and ST_RS_EMIT after setup, a first burst packet
//   through ST_BURST; output stalls hold the emit states.
// A flush caused by a reply into a full window ends with a commit of the held reply.
// Reset: window_size 5, seq_limit 50, next sequence 1, counts zero; list contents undefined.
// ----------------------------------------------------------------------------
// nak_retransmit_window_sender
// Sender side of a windowed NAK retransmission scheme: collects NAKs into a
// duplicate-free list and on flush sends resends followed by a fresh burst.
// ----------------------------------------------------------------------------
module nak_retransmit_window_sender
    import nrws_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  func,
    input  logic [SEQ_W-1:0]      reply_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [SEQ_W-1:0]      packet_value,
    output logic                  is_resend,
    output logic                  last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic [WSIZE_W-1:0] window_size_reg;
    logic [LIMIT_W-1:0] seq_limit_reg;
    logic               out_valid_reg;
    pkt_t               pkt_reg;
    logic               emit_valid;
    logic               emit_ready;
    pkt_t               emit;
    alu_req_t           alu_req;
    alu_res_t           alu_res;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [SEQ_W-1:0]   wr_data;
    logic [IDX_W-1:0]   rd_addr;
    logic [SEQ_W-1:0]   rd_data;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_SIZE_RST;
            seq_limit_reg   <= SEQ_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WINDOW_SIZE: window_size_reg <= cfg_data[WSIZE_W-1:0];
                REG_SEQ_LIMIT:   seq_limit_reg   <= cfg_data[LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    nrws_seq #(
        .MAX_WINDOW (MAX_WINDOW),
        .IDX_W      (IDX_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .func        (func),
        .reply_value (reply_value),
        .in_stall    (in_stall),
        .window_size (window_size_reg),
        .seq_limit   (seq_limit_reg),
        .emit_valid  (emit_valid),
        .emit_ready  (emit_ready),
        .emit        (emit),
        .alu_req     (alu_req),
        .alu_res     (alu_res),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    nrws_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    nrws_list #(
        .MAX_WINDOW (MAX_WINDOW),
        .IDX_W      (IDX_W)
    ) u_list (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register: load when empty or being taken
    assign emit_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_ready)
        begin
            out_valid_reg <= emit_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_valid && emit_ready)
        begin
            pkt_reg <= emit;
        end
    end

    assign out_valid    = out_valid_reg;
    assign packet_value = pkt_reg.packet_value;
    assign is_resend    = pkt_reg.is_resend;
    assign last         = pkt_reg.last;

endmodule
